[src/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the serial frame receiver
// Item structs, event and result codes, register map, compare unit bundles.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Input event codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_RDERR = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
	localparam logic [2:0] ERR_READ     = 3'd2;
	localparam logic [2:0] ERR_STRAY    = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW = 3'd4;
	localparam logic [2:0] ERR_BAD_END  = 3'd5;
	localparam logic [2:0] ERR_CHECKSUM = 3'd6;
	localparam logic [2:0] ERR_TYPE     = 3'd7;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_END     = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_BASE    = 2'd3;

	localparam logic [7:0]  RST_START   = 8'd126;
	localparam logic [7:0]  RST_END     = 8'd127;
	localparam logic [15:0] RST_TIMEOUT = 16'd100;
	localparam logic [7:0]  RST_BASE    = 8'd1;

	// Frame layout: start, recipient, type, length, checksum, payload, end
	localparam int FRAME_OVERHEAD = 6;
	localparam int POS_RCP        = 1;
	localparam int POS_TYPE       = 2;
	localparam int POS_LEN        = 3;
	localparam int POS_PAYLOAD    = 5;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	localparam int CMP_W = 16;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] recipient;
		logic [7:0] msg_type;
		logic [5:0] pay_len;
		logic [7:0] payload_byte;
		logic [2:0] err_code;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
	} cmp_req_t;

	typedef struct packed {
		logic eq;
		logic ge;
	} cmp_rsp_t;

endpackage

[src/sfr_cmp.sv]
// ----------------------------------------------------------------------------
// sfr_cmp: shared magnitude compare unit
// Unsigned equality and greater-or-equal over one operand pair.
// ----------------------------------------------------------------------------
module sfr_cmp import sfr_pkg::*; (
	input  cmp_req_t req,
	output cmp_rsp_t rsp
);

	logic [CMP_W:0] diff;

	// Borrow out of a - b clear means a >= b
	assign diff   = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.ge = ~diff[CMP_W];
	assign rsp.eq = (diff[CMP_W-1:0] == '0);

endmodule

[src/sfr_pbuf.sv]
// ----------------------------------------------------------------------------
// sfr_pbuf: payload byte buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfr_pbuf #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/serial_frame_receiver.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver: delimited frame receiver with XOR checksum
// A transaction is captured in the idle state and then executed; a frame's
// end byte runs the end, checksum, low type and high type checks in turn,
// then an error or the header leaves, followed by one payload result per
// cycle while the output is not stalled. The input stalls whenever the
// sequencer is not idle, so a new transaction is taken only once the last
// one is through. Reset clears config to defaults, goes idle and empties the
// output register.
// ----------------------------------------------------------------------------
module serial_frame_receiver import sfr_pkg::*; #(
	parameter int MAX_PAYLOAD = 32,
	parameter int NUM_TYPES   = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// Event input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	// Result output channel
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Byte count holds up to MAX_PAYLOAD + FRAME_OVERHEAD
	localparam int CW = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [CW-1:0] CNT_LIMIT   = CW'(MAX_PAYLOAD + FRAME_OVERHEAD);
	localparam logic [CW-1:0] PAY_END_POS = CW'(MAX_PAYLOAD + POS_PAYLOAD);

	// Sequencer states, one-hot
	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_EXEC     = 10'b00_0000_0010,
		S_FRAME    = 10'b00_0000_0100,
		S_CHK_END  = 10'b00_0000_1000,
		S_CHK_SUM  = 10'b00_0001_0000,
		S_CHK_TLO  = 10'b00_0010_0000,
		S_CHK_THI  = 10'b00_0100_0000,
		S_EMIT_ERR = 10'b00_1000_0000,
		S_EMIT_HDR = 10'b01_0000_0000,
		S_EMIT_PAY = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers
	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [15:0] tmo_q;
	logic [7:0]  base_q;

	// Frame tracking state
	logic          in_frame_q, in_frame_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    xor_q, xor_d;
	logic [15:0]   ticks_q, ticks_d;
	logic [7:0]    len_q, len_d;
	logic [7:0]    rcp_q, rcp_d;
	logic [7:0]    typ_q, typ_d;

	// Current transaction and sequencer scratch
	logic [1:0]    op_q, op_d;
	logic [7:0]    byte_q, byte_d;
	logic [2:0]    err_q, err_d;
	logic [AW-1:0] idx_q, idx_d;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      out_load;
	out_item_t out_next;
	logic      emit_ok;

	// Shared compare unit
	cmp_req_t cmp_req;
	cmp_rsp_t cmp_rsp;

	// Payload buffer ports
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	logic [15:0]   ticks_nxt;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] pay_off;
	logic [8:0]    frame_len;
	logic [8:0]    type_top;
	logic [8:0]    idx_inc;
	logic          cfg_wr;

	// ------------------------------------------------------------------
	// Configuration port: writes land on the access phase; always ready
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RST_START;
			end_q   <= RST_END;
			tmo_q   <= RST_TIMEOUT;
			base_q  <= RST_BASE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_START:   start_q <= pwdata[7:0];
				REG_END:     end_q   <= pwdata[7:0];
				REG_TIMEOUT: tmo_q   <= pwdata[15:0];
				REG_BASE:    base_q  <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START:   prdata = {24'd0, start_q};
			REG_END:     prdata = {24'd0, end_q};
			REG_TIMEOUT: prdata = {16'd0, tmo_q};
			REG_BASE:    prdata = {24'd0, base_q};
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Shared compare unit and payload buffer
	// ------------------------------------------------------------------
	sfr_cmp u_cmp (
		.req (cmp_req),
		.rsp (cmp_rsp)
	);

	sfr_pbuf #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_pbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (byte_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------
	// Idle tick counter saturates at all ones
	assign ticks_nxt = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 16'd1;
	assign count_inc = count_q + CW'(1);
	assign pay_off   = count_q - CW'(POS_PAYLOAD);
	assign wr_addr   = pay_off[AW-1:0];
	// Position just past the end byte, and one past the last accepted type
	assign frame_len = {1'b0, len_q} + 9'(FRAME_OVERHEAD);
	assign type_top  = {1'b0, base_q} + 9'(NUM_TYPES);
	assign idx_inc   = 9'(idx_q) + 9'd1;

	// The output register is free when empty or being drained this cycle
	assign emit_ok  = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != S_IDLE);

	// ------------------------------------------------------------------
	// Sequencer: one compare per step; unless the output stalls, one result per emit cycle
	// ------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		in_frame_d = in_frame_q;
		count_d    = count_q;
		xor_d      = xor_q;
		ticks_d    = ticks_q;
		len_d      = len_q;
		rcp_d      = rcp_q;
		typ_d      = typ_q;
		op_d       = op_q;
		byte_d     = byte_q;
		err_d      = err_q;
		idx_d      = idx_q;
		cmp_req    = '0;
		out_load   = 1'b0;
		out_next   = '0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;

		unique case (state_q)
			S_IDLE: begin
				// Capture the event transaction
				if (in_valid) begin
					op_d    = in_item.op;
					byte_d  = in_item.rx_byte;
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				case (op_q)
					OP_TICK: begin
						// Ignore ticks outside a frame; otherwise count and
						// fire once the count passes the limit
						if (!in_frame_q) begin
							state_d = S_IDLE;
						end else begin
							cmp_req.a = tmo_q;
							cmp_req.b = ticks_nxt;
							ticks_d   = ticks_nxt;
							if (!cmp_rsp.ge) begin
								in_frame_d = 1'b0;
								count_d    = '0;
								ticks_d    = '0;
								err_d      = ERR_TIMEOUT;
								state_d    = S_EMIT_ERR;
							end else begin
								state_d = S_IDLE;
							end
						end
					end
					OP_RDERR: begin
						// Report only; frame state stays as is
						err_d   = ERR_READ;
						state_d = S_EMIT_ERR;
					end
					OP_BYTE: begin
						ticks_d = '0;
						if (!in_frame_q) begin
							// Open a frame on the start byte, else flag a stray byte
							cmp_req.a = CMP_W'(byte_q);
							cmp_req.b = CMP_W'(start_q);
							if (cmp_rsp.eq) begin
								in_frame_d = 1'b1;
								count_d    = CW'(1);
								xor_d      = '0;
								state_d    = S_IDLE;
							end else begin
								count_d = '0;
								err_d   = ERR_STRAY;
								state_d = S_EMIT_ERR;
							end
						end else begin
							// Drop the frame once it is full
							cmp_req.a = CMP_W'(count_q);
							cmp_req.b = CMP_W'(CNT_LIMIT);
							if (cmp_rsp.ge) begin
								in_frame_d = 1'b0;
								count_d    = '0;
								err_d      = ERR_OVERFLOW;
								state_d    = S_EMIT_ERR;
							end else begin
								state_d = S_FRAME;
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
			end

			S_FRAME: begin
				// Is this byte the closing position of the frame?
				cmp_req.a = CMP_W'(count_inc);
				cmp_req.b = CMP_W'(frame_len);
				count_d   = count_inc;
				if (cmp_rsp.eq) begin
					in_frame_d = 1'b0;
					count_d    = '0;
					state_d    = S_CHK_END;
				end else begin
					// Fold into the checksum and store header or payload
					xor_d = xor_q ^ byte_q;
					if (count_q == CW'(POS_RCP)) begin
						rcp_d = byte_q;
					end
					if (count_q == CW'(POS_TYPE)) begin
						typ_d = byte_q;
					end
					if (count_q == CW'(POS_LEN)) begin
						len_d = byte_q;
					end
					if (count_q >= CW'(POS_PAYLOAD) && count_q < PAY_END_POS) begin
						wr_en = 1'b1;
					end
					state_d = S_IDLE;
				end
			end

			S_CHK_END: begin
				cmp_req.a = CMP_W'(byte_q);
				cmp_req.b = CMP_W'(end_q);
				if (!cmp_rsp.eq) begin
					err_d   = ERR_BAD_END;
					state_d = S_EMIT_ERR;
				end else begin
					state_d = S_CHK_SUM;
				end
			end

			S_CHK_SUM: begin
				// XOR over recipient..payload, checksum included, must be zero
				cmp_req.a = CMP_W'(xor_q);
				cmp_req.b = '0;
				if (!cmp_rsp.eq) begin
					err_d   = ERR_CHECKSUM;
					state_d = S_EMIT_ERR;
				end else begin
					state_d = S_CHK_TLO;
				end
			end

			S_CHK_TLO: begin
				cmp_req.a = CMP_W'(typ_q);
				cmp_req.b = CMP_W'(base_q);
				if (!cmp_rsp.ge) begin
					err_d   = ERR_TYPE;
					state_d = S_EMIT_ERR;
				end else begin
					state_d = S_CHK_THI;
				end
			end

			S_CHK_THI: begin
				cmp_req.a = CMP_W'(typ_q);
				cmp_req.b = CMP_W'(type_top);
				if (cmp_rsp.ge) begin
					err_d   = ERR_TYPE;
					state_d = S_EMIT_ERR;
				end else begin
					state_d = S_EMIT_HDR;
				end
			end

			S_EMIT_ERR: begin
				if (emit_ok) begin
					out_load          = 1'b1;
					out_next.kind     = KIND_ERROR;
					out_next.err_code = err_q;
					out_next.last     = 1'b1;
					state_d           = S_IDLE;
				end
			end

			S_EMIT_HDR: begin
				if (emit_ok) begin
					out_load           = 1'b1;
					out_next.kind      = KIND_HEADER;
					out_next.recipient = rcp_q;
					out_next.msg_type  = typ_q;
					out_next.pay_len   = len_q[5:0];
					out_next.last      = (len_q == 8'd0);
					if (len_q == 8'd0) begin
						state_d = S_IDLE;
					end else begin
						// Prefetch the first payload byte
						rd_en   = 1'b1;
						rd_addr = '0;
						idx_d   = '0;
						state_d = S_EMIT_PAY;
					end
				end
			end

			S_EMIT_PAY: begin
				if (emit_ok) begin
					out_load              = 1'b1;
					out_next.kind         = KIND_PAYLOAD;
					out_next.payload_byte = rd_data;
					out_next.last         = (idx_inc == {1'b0, len_q});
					if (idx_inc == {1'b0, len_q}) begin
						state_d = S_IDLE;
					end else begin
						// Advance and fetch the next byte
						rd_en   = 1'b1;
						rd_addr = idx_inc[AW-1:0];
						idx_d   = idx_inc[AW-1:0];
					end
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_frame_q  <= 1'b0;
			count_q     <= '0;
			xor_q       <= '0;
			ticks_q     <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			xor_q      <= xor_d;
			ticks_q    <= ticks_d;
			len_q      <= len_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		rcp_q  <= rcp_d;
		typ_q  <= typ_d;
		op_q   <= op_d;
		byte_q <= byte_d;
		err_q  <= err_d;
		idx_q  <= idx_d;
		if (out_load) begin
			out_item_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[src/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks for the serial frame receiver
// Watches both channels and the shape of emitted results.
// ----------------------------------------------------------------------------
module sfr_checker import sfr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// One event at a time: input stalls right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// Error reports always close their run
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_ERROR |-> out_item.last)
		else $error("error result without last");

	// Empty-payload header is the whole run
	a_empty_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_HEADER && out_item.pay_len == 6'd0
		|-> out_item.last)
		else $error("empty frame header without last");

	// Held result stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
